// ----- hw/rtl/pfm_pkg.sv -----
`timescale 1ns / 1ps

package pfm_pkg;

   localparam int MAX_SIDE_DEFAULT = 4096;

   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_KIND   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic [2:0] KIND_BYTE         = 3'd0;
   localparam logic [2:0] KIND_HALF         = 3'd1;
   localparam logic [2:0] KIND_COMPLEX_F32  = 3'd2;
   localparam logic [2:0] KIND_COMPLEX_HALF = 3'd3;
   localparam logic [2:0] KIND_F32          = 3'd4;

   localparam logic [31:0] FP_CANON_NAN = 32'h7FC0_0000;
   localparam logic [31:0] FP_INF       = 32'h7F80_0000;

   // binary16 to binary32, exact; exponent 31 maps to signed infinity
   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [4:0]  e;
      logic [9:0]  m;
      logic [3:0]  pos;
      logic [3:0]  sh;
      logic [19:0] mx;
      logic [7:0]  be;
      logic [31:0] r;
      e   = h[14:10];
      m   = h[9:0];
      pos = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (m[i]) begin
            pos = 4'(i);
         end
      end
      sh = 4'd10 - pos;
      mx = {10'b0, m} << sh;
      be = 8'd113 - {4'b0, sh};
      if (e == 5'h1F) begin
         r = {h[15], 31'h7F80_0000};
      end else if (e == 5'd0) begin
         if (m == 10'd0) begin
            r = {h[15], 31'd0};
         end else begin
            r = {h[15], be, mx[9:0], 13'd0};
         end
      end else begin
         r = {h[15], 8'({3'b0, e} + 8'd112), m, 13'd0};
      end
      return r;
   endfunction

   function automatic logic [31:0] byte_to_single(input logic [7:0] b);
      logic [2:0]  pos;
      logic [30:0] t;
      logic [31:0] r;
      pos = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            pos = 3'(i);
         end
      end
      t = {23'd0, b} << (5'd23 - {2'b0, pos});
      if (b == 8'd0) begin
         r = 32'd0;
      end else begin
         r = {1'b0, 8'd127 + {5'b0, pos}, t[22:0]};
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/pixel_format_to_float_magnitude.sv -----
`timescale 1ns / 1ps

// Pixel decoder: one raw big-endian pixel in, one single-precision value out.
// Input transfers on req_valid & !req_stall, results on rsp_valid & !rsp_stall.
// Registers are written through csr_write/csr_index/csr_data; the user must
// write them only while idle, which the block does not enforce: 0 pixel kind,
// 1 image width, 2 image height. Byte, half and float32 pixels are converted
// in the transfer cycle and the result is shown the cycle after; a new pixel is
// taken every cycle while the output is not stalled. Complex pixels without a
// NaN part run through one shared sequencer: two squares on a 24x24 multiplier,
// alignment and add, normalization by a one-bit-per-cycle shifter and rounding,
// then a 25-step digit-recurrence square root. Alignment shifts the smaller
// square step by step by the exponent gap, a gap over 26 going into a sticky
// bit, and tiny or subnormal operands add normalize/denormalize steps; a zero
// or infinite sum skips the square root. req_stall is high the whole time.
// A finished result sits in the output register until taken; while rsp_stall
// holds it there, req_stall is high too, and a complex result waits in its
// last step. rsp_row_end and rsp_image_end mark the raster position.
// Reset empties the block, sets kind float32, size 1x1 and counters to zero.
module pixel_format_to_float_magnitude
   import pfm_pkg::*;
#(
   parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [63:0]            req_raw_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [31:0]            rsp_pixel_value,
   output logic                   rsp_row_end,
   output logic                   rsp_image_end,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int SW = ($clog2(MAX_SIDE + 1) > 13) ? $clog2(MAX_SIDE + 1) : 14;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MUL    = 4'd1;
   localparam logic [3:0] S_NORM   = 4'd2;
   localparam logic [3:0] S_DEN    = 4'd3;
   localparam logic [3:0] S_RND    = 4'd4;
   localparam logic [3:0] S_ADDSET = 4'd5;
   localparam logic [3:0] S_ALIGN  = 4'd6;
   localparam logic [3:0] S_SQSET  = 4'd7;
   localparam logic [3:0] S_SQNORM = 4'd8;
   localparam logic [3:0] S_SQRT   = 4'd9;
   localparam logic [3:0] S_SQFIN  = 4'd10;
   localparam logic [3:0] S_DONE   = 4'd11;

   localparam logic [1:0] PH_RE  = 2'd0;
   localparam logic [1:0] PH_IM  = 2'd1;
   localparam logic [1:0] PH_SUM = 2'd2;

   logic [2:0]  kind_ff;
   logic [12:0] width_ff, height_ff;
   logic [CW-1:0] col_ff, col_in, row_ff, row_in;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic [31:0] re_ff, re_in, im_ff, im_in, p_ff, p_in, q_ff, q_in;
   logic [49:0] sig_ff, sig_in, b_ff, b_in;
   logic [49:0] res_ff, res_in, bit_ff, bit_in;
   logic signed [10:0] exp_ff, exp_in;
   logic [7:0]  d_ff, d_in;
   logic        inf_ff, inf_in;
   logic        rend_ff, rend_in, iend_ff, iend_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic        rsp_row_end_ff, rsp_row_end_in;
   logic        rsp_image_end_ff, rsp_image_end_in;

   logic        accept;
   logic [SW-1:0] w_sat, h_sat, w_ext, h_ext;
   logic        rend, iend;
   logic [31:0] simple_value, op, a_v, b_v, rnd_value, sq_value;
   logic [31:0] re_a, im_a;
   logic        nan_in;
   logic [7:0]  op_e, a_e, b_e;
   logic [47:0] prod;
   logic [24:0] rnd_r;
   logic        rnd_inc;
   logic signed [10:0] rnd_exp;
   logic [50:0] sq_t;
   logic [25:0] sq_q, sq_r;
   logic        sq_inc;
   logic signed [10:0] sq_be, sq_half;
   logic [24:0] sq_m;

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_value_ff;
   assign rsp_row_end     = rsp_row_end_ff;
   assign rsp_image_end   = rsp_image_end_ff;

   always_comb begin
      w_ext = SW'(width_ff);
      h_ext = SW'(height_ff);
      if (w_ext == '0) begin
         w_sat = SW'(1);
      end else if (w_ext > SW'(MAX_SIDE)) begin
         w_sat = SW'(MAX_SIDE);
      end else begin
         w_sat = w_ext;
      end
      if (h_ext == '0) begin
         h_sat = SW'(1);
      end else if (h_ext > SW'(MAX_SIDE)) begin
         h_sat = SW'(MAX_SIDE);
      end else begin
         h_sat = h_ext;
      end
      rend = SW'(col_ff) >= (w_sat - SW'(1));
      iend = rend && (SW'(row_ff) >= (h_sat - SW'(1)));
   end

   always_comb begin
      re_a = req_raw_pixel[63:32];
      im_a = req_raw_pixel[31:0];
      if (kind_ff == KIND_COMPLEX_HALF) begin
         re_a = half_to_single(req_raw_pixel[31:16]);
         im_a = half_to_single(req_raw_pixel[15:0]);
      end
      nan_in = (re_a[30:23] == 8'hFF && re_a[22:0] != 23'd0)
            || (im_a[30:23] == 8'hFF && im_a[22:0] != 23'd0);
      case (kind_ff)
         KIND_BYTE: simple_value = byte_to_single(req_raw_pixel[7:0]);
         KIND_HALF: simple_value = half_to_single(req_raw_pixel[15:0]);
         KIND_COMPLEX_F32,
         KIND_COMPLEX_HALF: simple_value = FP_CANON_NAN;
         default: simple_value = req_raw_pixel[31:0];
      endcase
   end

   // rounding of sig_ff/exp_ff to a positive single
   always_comb begin
      rnd_inc = sig_ff[24] && ((|sig_ff[23:0]) || sig_ff[25]);
      rnd_r   = {1'b0, sig_ff[48:25]} + {24'd0, rnd_inc};
      rnd_exp = exp_ff;
      if (rnd_r[24]) begin
         rnd_r   = rnd_r >> 1;
         rnd_exp = exp_ff + 11'sd1;
      end
      if (inf_ff || rnd_exp >= 11'sd255) begin
         rnd_value = FP_INF;
      end else begin
         rnd_value = {1'b0, rnd_r[23] ? rnd_exp[7:0] : 8'd0, rnd_r[22:0]};
      end
   end

   always_comb begin
      op   = (phase_ff == PH_RE) ? re_ff : im_ff;
      op_e = (op[30:23] == 8'd0) ? 8'd1 : op[30:23];
      prod = {op[30:23] != 8'd0, op[22:0]} * {op[30:23] != 8'd0, op[22:0]};
      if (p_ff[30:23] >= q_ff[30:23]) begin
         a_v = p_ff;
         b_v = q_ff;
      end else begin
         a_v = q_ff;
         b_v = p_ff;
      end
      a_e = (a_v[30:23] == 8'd0) ? 8'd1 : a_v[30:23];
      b_e = (b_v[30:23] == 8'd0) ? 8'd1 : b_v[30:23];
      sq_t    = {1'b0, res_ff} + {1'b0, bit_ff};
      sq_q    = res_ff[25:0];
      sq_r    = sq_q >> 1;
      sq_inc  = sq_q[0] && (sig_ff != '0 || sq_r[0]);
      sq_r    = sq_r + {25'd0, sq_inc};
      sq_half = (exp_ff - 11'sd25) >>> 1;
      sq_be   = sq_half + 11'sd151;
      if (sq_r[24]) begin
         sq_r  = sq_r >> 1;
         sq_be = sq_be + 11'sd1;
      end
      sq_value = {1'b0, sq_be[7:0], sq_r[22:0]};
      sq_m     = exp_ff[0] ? sig_ff[24:0] : {sig_ff[23:0], 1'b0};
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      re_in = re_ff;
      im_in = im_ff;
      p_in = p_ff;
      q_in = q_ff;
      sig_in = sig_ff;
      b_in = b_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      exp_in = exp_ff;
      d_in = d_ff;
      inf_in = inf_ff;
      rend_in = rend_ff;
      iend_in = iend_ff;
      col_in = col_ff;
      row_in = row_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_row_end_in = rsp_row_end_ff;
      rsp_image_end_in = rsp_image_end_ff;

      if (accept) begin
         rend_in = rend;
         iend_in = iend;
         if (rend) begin
            col_in = '0;
            row_in = iend ? '0 : row_ff + CW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
         re_in = re_a;
         im_in = im_a;
         phase_in = PH_RE;
         if ((kind_ff == KIND_COMPLEX_F32 || kind_ff == KIND_COMPLEX_HALF) && !nan_in) begin
            state_in = S_MUL;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_value_in = simple_value;
            rsp_row_end_in = rend;
            rsp_image_end_in = iend;
         end
      end

      case (state_ff)
         S_IDLE: begin
         end
         S_MUL: begin
            sig_in = {1'b0, prod, 1'b0};
            exp_in = $signed({2'b0, op_e, 1'b0}) - 11'sd126;
            inf_in = (op[30:23] == 8'hFF);
            state_in = S_NORM;
         end
         S_NORM: begin
            if (sig_ff[49]) begin
               sig_in = {1'b0, sig_ff[49:2], sig_ff[1] | sig_ff[0]};
               exp_in = exp_ff + 11'sd1;
            end else if (sig_ff != '0 && !sig_ff[48] && exp_ff > 11'sd1) begin
               sig_in = {sig_ff[48:0], 1'b0};
               exp_in = exp_ff - 11'sd1;
            end else begin
               state_in = S_DEN;
            end
         end
         S_DEN: begin
            if (sig_ff == '0 || exp_ff >= 11'sd1) begin
               state_in = S_RND;
            end else if (exp_ff < -11'sd30) begin
               sig_in = {49'd0, 1'b1};
               exp_in = 11'sd1;
            end else begin
               sig_in = {1'b0, sig_ff[49:2], sig_ff[1] | sig_ff[0]};
               exp_in = exp_ff + 11'sd1;
            end
         end
         S_RND: begin
            case (phase_ff)
               PH_RE: begin
                  p_in = rnd_value;
                  phase_in = PH_IM;
                  state_in = S_MUL;
               end
               PH_IM: begin
                  q_in = rnd_value;
                  phase_in = PH_SUM;
                  state_in = S_ADDSET;
               end
               default: begin
                  p_in = rnd_value;
                  state_in = S_SQSET;
               end
            endcase
         end
         S_ADDSET: begin
            sig_in = {1'b0, a_v[30:23] != 8'd0, a_v[22:0], 25'd0};
            b_in = {1'b0, b_v[30:23] != 8'd0, b_v[22:0], 25'd0};
            d_in = a_e - b_e;
            exp_in = $signed({3'b0, a_e});
            inf_in = (p_ff[30:23] == 8'hFF) || (q_ff[30:23] == 8'hFF);
            state_in = S_ALIGN;
         end
         S_ALIGN: begin
            if (d_ff == 8'd0) begin
               sig_in = sig_ff + b_ff;
               state_in = S_NORM;
            end else if (d_ff > 8'd26) begin
               b_in = {49'd0, |b_ff};
               d_in = 8'd0;
            end else begin
               b_in = {1'b0, b_ff[49:2], b_ff[1] | b_ff[0]};
               d_in = d_ff - 8'd1;
            end
         end
         S_SQSET: begin
            if (p_ff[30:23] == 8'hFF) begin
               p_in = FP_INF;
               state_in = S_DONE;
            end else if (p_ff[30:0] == 31'd0) begin
               p_in = 32'd0;
               state_in = S_DONE;
            end else begin
               sig_in = {26'd0, p_ff[30:23] != 8'd0, p_ff[22:0]};
               exp_in = (p_ff[30:23] == 8'd0) ? -11'sd149
                      : $signed({3'b0, p_ff[30:23]}) - 11'sd150;
               state_in = S_SQNORM;
            end
         end
         S_SQNORM: begin
            if (!sig_ff[23]) begin
               sig_in = {sig_ff[48:0], 1'b0};
               exp_in = exp_ff - 11'sd1;
            end else begin
               sig_in = {sq_m, 25'd0};
               if (!exp_ff[0]) begin
                  exp_in = exp_ff - 11'sd1;
               end
               res_in = '0;
               bit_in = 50'd1 << 48;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if ({1'b0, sig_ff} >= sq_t) begin
               sig_in = sig_ff - sq_t[49:0];
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = S_SQFIN;
            end
         end
         S_SQFIN: begin
            p_in = sq_value;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = p_ff;
               rsp_row_end_in = rend_ff;
               rsp_image_end_in = iend_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         col_ff <= '0;
         row_ff <= '0;
         kind_ff <= KIND_F32;
         width_ff <= 13'd1;
         height_ff <= 13'd1;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_write) begin
            case (csr_index)
               CSR_PIXEL_KIND: kind_ff <= csr_data[2:0];
               CSR_IMAGE_WIDTH: width_ff <= csr_data;
               CSR_IMAGE_HEIGHT: height_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      re_ff <= re_in;
      im_ff <= im_in;
      p_ff <= p_in;
      q_ff <= q_in;
      sig_ff <= sig_in;
      b_ff <= b_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      exp_ff <= exp_in;
      d_ff <= d_in;
      inf_ff <= inf_in;
      rend_ff <= rend_in;
      iend_ff <= iend_in;
      rsp_value_ff <= rsp_value_in;
      rsp_row_end_ff <= rsp_row_end_in;
      rsp_image_end_ff <= rsp_image_end_in;
   end

endmodule

// ----- test/pixel_format_to_float_magnitude_tb.sv -----
`timescale 1ns / 1ps

module pixel_format_to_float_magnitude_tb;
   import pfm_pkg::*;

   localparam int          CYCLE_LIMIT   = 1500000;
   localparam int          RANDOM_PIXELS = 1200;
   localparam logic [2:0]  KIND_RESERVED = 3'd7;
   localparam logic [31:0] SP_INF        = 32'h7F80_0000;
   localparam logic [31:0] SP_QNAN       = 32'h7FC0_0000;

   typedef struct {
      logic [31:0] value;
      logic        row_end;
      logic        image_end;
   } pixel_result_type;

   typedef struct {
      logic [2:0]  kind;
      logic [63:0] raw;
      bit          fixed;
      logic [31:0] value;
   } pixel_case_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [63:0]            req_raw_pixel = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [31:0]            rsp_pixel_value;
   logic                   rsp_row_end;
   logic                   rsp_image_end;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   pixel_result_type pending_pixels[$];
   int            errors = 0;
   int            cycles = 0;
   int            pixels_sent = 0;
   int            stall_pct = 0;
   int            burst_left = 0;
   int            gap_max = 0;

   // predictor state
   logic [2:0]  cur_kind = KIND_F32;
   logic [12:0] cur_width = 13'd1;
   logic [12:0] cur_height = 13'd1;
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;

   pixel_format_to_float_magnitude dut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("pixel_format_to_float_magnitude regression: fail");
         $finish;
      end
   end

   // receiver: random stalls plus occasional long hold-offs
   initial begin : receiver
      int own_cycles;
      int hold;
      own_cycles = 0;
      hold = 0;
      forever begin
         @(posedge clock);
         own_cycles++;
         if (own_cycles % 20000 == 3000) begin
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            errors++;
            $display("%0t: unexpected transfer value %h", $time, rsp_pixel_value);
         end else begin
            pixel_result_type exp_r;
            exp_r = pending_pixels.pop_front();
            if (rsp_pixel_value !== exp_r.value) begin
               errors++;
               $display("%0t: pixel_value expected %h got %h", $time, exp_r.value,
                        rsp_pixel_value);
            end
            if (rsp_row_end !== exp_r.row_end) begin
               errors++;
               $display("%0t: row_end expected %b got %b", $time, exp_r.row_end,
                        rsp_row_end);
            end
            if (rsp_image_end !== exp_r.image_end) begin
               errors++;
               $display("%0t: image_end expected %b got %b", $time, exp_r.image_end,
                        rsp_image_end);
            end
         end
      end
   end

   // exact value m * 2^e (non-negative) rounded to single, nearest even
   function automatic logic [31:0] round_single(input logic [319:0] m, input int e);
      int           n;
      int           lsb;
      int           sh;
      int           biased;
      logic [319:0] q;
      logic [319:0] mask;
      logic         guard;
      logic         sticky;
      if (m == '0) return 32'd0;
      n = 0;
      for (int i = 0; i < 320; i++) begin
         if (m[i]) n = i;
      end
      lsb = n + e - 23;
      if (lsb < -149) lsb = -149;
      sh = lsb - e;
      if (sh <= 0) begin
         q = m << (-sh);
         guard = 1'b0;
         sticky = 1'b0;
      end else if (sh > 320) begin
         q = '0;
         guard = 1'b0;
         sticky = 1'b1;
      end else begin
         q = m >> sh;
         guard = m[sh-1];
         mask = (320'd1 << (sh - 1)) - 320'd1;
         sticky = |(m & mask);
      end
      if (guard && (sticky || q[0])) q = q + 320'd1;
      if (q[24]) begin
         q = q >> 1;
         lsb++;
      end
      if (q[23]) begin
         biased = lsb + 150;
         if (biased >= 255) return SP_INF;
         return {1'b0, 8'(biased), q[22:0]};
      end
      return {9'd0, q[22:0]};
   endfunction

   function automatic void split_single(input logic [31:0] b, output logic [319:0] m,
                                        output int e);
      if (b[30:23] == 8'd0) begin
         m = {297'd0, b[22:0]};
         e = -149;
      end else begin
         m = {296'd0, 1'b1, b[22:0]};
         e = int'(b[30:23]) - 150;
      end
   endfunction

   function automatic logic [31:0] widen_half(input logic [15:0] h);
      logic [31:0] mag;
      if (h[14:10] == 5'h1F) begin
         mag = SP_INF;
      end else if (h[14:10] == 5'd0) begin
         mag = round_single({310'd0, h[9:0]}, -24);
      end else begin
         mag = round_single({309'd0, 1'b1, h[9:0]}, int'(h[14:10]) - 25);
      end
      return {h[15], mag[30:0]};
   endfunction

   function automatic logic [31:0] square_single(input logic [31:0] b);
      logic [319:0] m;
      int           e;
      if (b[30:23] == 8'hFF) return SP_INF;
      split_single(b, m, e);
      return round_single(m * m, 2 * e);
   endfunction

   function automatic logic [31:0] sqrt_single(input logic [31:0] s);
      logic [319:0]    m;
      int              e;
      int              k;
      longint unsigned big;
      longint unsigned r;
      longint unsigned t;
      if (s == 32'd0) return 32'd0;
      split_single(s, m, e);
      // subnormal sums: bring the leading one to bit 23 so the root keeps enough bits
      while (!m[23]) begin
         m = m << 1;
         e--;
      end
      k = ((e - 36) & 1) ? 37 : 36;
      big = longint'(m[63:0]) << k;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (t * t <= big) r = t;
      end
      return round_single({255'd0, r[63:0], (r * r != big)}, (e - k) / 2 - 1);
   endfunction

   function automatic logic [31:0] complex_magnitude(input logic [31:0] re,
                                                     input logic [31:0] im);
      logic [31:0]  p;
      logic [31:0]  q;
      logic [319:0] mp;
      logic [319:0] mq;
      int           ep;
      int           eq;
      int           e0;
      logic [31:0]  s;
      if ((re[30:23] == 8'hFF && re[22:0] != 0) || (im[30:23] == 8'hFF && im[22:0] != 0))
         return SP_QNAN;
      p = square_single(re);
      q = square_single(im);
      if (p == SP_INF || q == SP_INF) return SP_INF;
      split_single(p, mp, ep);
      split_single(q, mq, eq);
      e0 = (ep < eq) ? ep : eq;
      s = round_single((mp << (ep - e0)) + (mq << (eq - e0)), e0);
      if (s == SP_INF) return SP_INF;
      return sqrt_single(s);
   endfunction

   function automatic int unsigned side_of(input logic [12:0] v);
      if (v == 13'd0) return 1;
      if (v > 13'd4096) return 4096;
      return int'(v);
   endfunction

   task automatic decode_pixel(input logic [63:0] raw, output pixel_result_type r);
      int unsigned w;
      int unsigned h;
      w = side_of(cur_width);
      h = side_of(cur_height);
      case (cur_kind)
         KIND_BYTE: r.value = round_single({312'd0, raw[7:0]}, 0);
         KIND_HALF: r.value = widen_half(raw[15:0]);
         KIND_COMPLEX_F32: r.value = complex_magnitude(raw[63:32], raw[31:0]);
         KIND_COMPLEX_HALF: r.value = complex_magnitude(widen_half(raw[31:16]),
                                                         widen_half(raw[15:0]));
         default: r.value = raw[31:0];
      endcase
      r.row_end = (col_pos >= w - 1);
      r.image_end = r.row_end && (row_pos >= h - 1);
      if (r.row_end) begin
         col_pos = 0;
         row_pos = r.image_end ? 0 : row_pos + 1;
      end else begin
         col_pos++;
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [12:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_PIXEL_KIND: cur_kind = val[2:0];
         CSR_IMAGE_WIDTH: cur_width = val;
         default: cur_height = val;
      endcase
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // offers one pixel, waits for its transfer, then maybe leaves a gap
   task automatic send_pixel(input logic [63:0] raw, input bit fixed,
                             input logic [31:0] value);
      pixel_result_type r;
      int            gap;
      req_valid <= 1'b1;
      req_raw_pixel <= raw;
      do @(posedge clock); while (!(req_valid && !req_stall));
      decode_pixel(raw, r);
      if (fixed) r.value = value;
      pending_pixels.push_back(r);
      pixels_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 20);
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic logic [31:0] rand_single();
      logic [31:0] b;
      b = $urandom;
      case ($urandom_range(9))
         0: b[30:0] = 31'd0;
         1: b[30:0] = SP_INF[30:0];
         2: b[30:23] = 8'hFF;
         3: b[30:23] = 8'd0;
         4: b[30:23] = 8'($urandom_range(8'hF0, 8'hFE));
         5: b[30:23] = 8'($urandom_range(1, 8'h20));
         default: b[30:23] = 8'($urandom_range(107, 147));
      endcase
      return b;
   endfunction

   function automatic logic [15:0] rand_half();
      logic [15:0] h;
      h = 16'($urandom);
      case ($urandom_range(7))
         0: h[14:10] = 5'd0;
         1: h[14:10] = 5'h1F;
         2: h[14:0] = 15'd0;
         default: ;
      endcase
      return h;
   endfunction

   function automatic logic [63:0] rand_raw(input logic [2:0] kind);
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      if ($urandom_range(7) != 0) begin
         if (kind == KIND_COMPLEX_F32) raw = {rand_single(), rand_single()};
         if (kind == KIND_COMPLEX_HALF) raw[31:0] = {rand_half(), rand_half()};
         if (kind == KIND_HALF) raw[15:0] = rand_half();
      end
      return raw;
   endfunction

   function automatic logic [12:0] rand_side();
      case ($urandom_range(11))
         0: return 13'd0;
         1: return 13'd4096;
         2: return 13'h1FFF;
         3: return 13'($urandom_range(4097, 8190));
         4: return 13'($urandom_range(7, 300));
         default: return 13'($urandom_range(1, 6));
      endcase
   endfunction

   pixel_case_type pixel_cases[21] = '{
      '{KIND_F32,          64'hFFFF_FFFF_7FC1_2345, 1'b1, 32'h7FC1_2345},
      '{KIND_F32,          64'h0123_4567_89AB_CDEF, 1'b1, 32'h89AB_CDEF},
      '{KIND_BYTE,         64'h0,                   1'b1, 32'h0},
      '{KIND_BYTE,         64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'h437F_0000},
      '{KIND_BYTE,         64'hA5A5_A5A5_A5A5_A580, 1'b1, 32'h4300_0000},
      '{KIND_HALF,         64'h3C00,                1'b1, 32'h3F80_0000},
      '{KIND_HALF,         64'h7C00,                1'b1, 32'h7F80_0000},
      '{KIND_HALF,         64'hFFFF_FFFF_FFFF_FE01, 1'b1, 32'hFF80_0000},
      '{KIND_HALF,         64'h0001,                1'b1, 32'h3380_0000},
      '{KIND_HALF,         64'h83FF,                1'b0, 32'h0},
      '{KIND_HALF,         64'h7BFF,                1'b1, 32'h477F_E000},
      '{KIND_COMPLEX_F32,  64'h4040_0000_4080_0000, 1'b1, 32'h40A0_0000},
      '{KIND_COMPLEX_F32,  64'h7FC0_0000_0000_0000, 1'b1, 32'h7FC0_0000},
      '{KIND_COMPLEX_F32,  64'hFF80_0000_7FC0_0001, 1'b1, 32'h7FC0_0000},
      '{KIND_COMPLEX_F32,  64'hFF80_0000_3F80_0000, 1'b1, 32'h7F80_0000},
      '{KIND_COMPLEX_F32,  64'h7F7F_FFFF_0000_0000, 1'b1, 32'h7F80_0000},
      '{KIND_COMPLEX_F32,  64'h0000_0001_0000_0001, 1'b1, 32'h0},
      '{KIND_COMPLEX_HALF, 64'hFFFF_0000_4200_4400, 1'b1, 32'h40A0_0000},
      '{KIND_COMPLEX_HALF, 64'h7C00_0001,           1'b1, 32'h7F80_0000},
      '{KIND_COMPLEX_HALF, 64'h0001_0001,           1'b0, 32'h0},
      '{KIND_RESERVED,     64'h0000_0000_DEAD_BEEF, 1'b1, 32'hDEAD_BEEF}
   };

   initial begin : stimulus
      int phase_items;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (pixel_cases[i]) begin
         if (pixel_cases[i].kind != cur_kind) begin
            drain();
            write_reg(CSR_PIXEL_KIND, {10'd0, pixel_cases[i].kind});
         end
         send_pixel(pixel_cases[i].raw, pixel_cases[i].fixed, pixel_cases[i].value);
      end
      drain();
      write_reg(CSR_IMAGE_WIDTH, 13'd3);
      write_reg(CSR_IMAGE_HEIGHT, 13'd2);

      pixels_sent = 0;
      while (pixels_sent < RANDOM_PIXELS) begin
         stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 70);
         gap_max = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
         phase_items = $urandom_range(20, 80);
         repeat (phase_items) send_pixel(rand_raw(cur_kind), 1'b0, 32'h0);
         drain();
         if ($urandom_range(1)) write_reg(CSR_PIXEL_KIND, 13'($urandom_range(7)));
         if ($urandom_range(1)) write_reg(CSR_IMAGE_WIDTH, rand_side());
         if ($urandom_range(1)) write_reg(CSR_IMAGE_HEIGHT, rand_side());
      end
      drain();
      repeat (50) @(posedge clock);
      if (errors == 0 && pending_pixels.size() == 0) begin
         $display("pixel_format_to_float_magnitude regression: pass");
      end else begin
         $display("pixel_format_to_float_magnitude regression: fail");
      end
      $finish;
   end

endmodule
